@@ rtl/cat_pkg.sv @@
// Shared types and defaults for the copy alias table.
// Used by cat_front, cat_back and copy_alias_table; depends on nothing.
`timescale 1ns / 1ps

package cat_pkg;

    // Default table size and id width
    localparam int TABLE_ENTRIES = 32;
    localparam int VAR_ID_BITS   = 16;

    // Request kinds as they arrive on the input channel
    typedef enum logic [2:0] {
        REQ_COPY       = 3'd0,
        REQ_COMPUTE    = 3'd1,
        REQ_READ_PAIR  = 3'd2,
        REQ_READ_ONE   = 3'd3,
        REQ_KILL       = 3'd4,
        REQ_CLEAR      = 3'd5,
        REQ_CLEAR_READ = 3'd6
    } req_t;

    // Operations after classification
    typedef enum logic [2:0] {
        OP_NOP,
        OP_CLEAR,
        OP_READ,
        OP_KILL,
        OP_COMPUTE,
        OP_COPY
    } op_t;

    // Control word carried through the queue
    typedef struct packed {
        op_t  op;
        logic rd_a;
        logic rd_b;
    } ctl_t;

endpackage

@@ rtl/cat_front.sv @@
// Front end of the copy alias table: classifies incoming requests and
// queues them in a two-entry queue. Depends on cat_pkg.
`timescale 1ns / 1ps

module cat_front #(
    parameter int VAR_ID_BITS = cat_pkg::VAR_ID_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // request side
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [2:0]             in_req,
    input  logic                   in_label,
    input  logic [VAR_ID_BITS-1:0] in_dest,
    input  logic [VAR_ID_BITS-1:0] in_a,
    input  logic [VAR_ID_BITS-1:0] in_b,
    // queue head towards the back end
    output logic                   q_valid,
    input  logic                   q_ready,
    output cat_pkg::ctl_t          q_ctl,
    output logic [VAR_ID_BITS-1:0] q_dest,
    output logic [VAR_ID_BITS-1:0] q_a,
    output logic [VAR_ID_BITS-1:0] q_b
);

    cat_pkg::ctl_t          ctl_in;
    cat_pkg::ctl_t          q_ctl_reg  [2];
    logic [VAR_ID_BITS-1:0] q_dest_reg [2];
    logic [VAR_ID_BITS-1:0] q_a_reg    [2];
    logic [VAR_ID_BITS-1:0] q_b_reg    [2];
    logic                   wptr_reg;
    logic                   rptr_reg;
    logic [1:0]             count_reg;
    logic                   push;
    logic                   pop;

    // Classify the request
    always_comb
    begin
        ctl_in.op   = cat_pkg::OP_NOP;
        ctl_in.rd_a = 1'b0;
        ctl_in.rd_b = 1'b0;
        unique case (cat_pkg::req_t'(in_req))
            cat_pkg::REQ_COPY:
            begin
                ctl_in.op = in_label ? cat_pkg::OP_NOP : cat_pkg::OP_COPY;
            end
            cat_pkg::REQ_COMPUTE:
            begin
                ctl_in.op   = cat_pkg::OP_COMPUTE;
                ctl_in.rd_a = 1'b1;
                ctl_in.rd_b = 1'b1;
            end
            cat_pkg::REQ_READ_PAIR:
            begin
                ctl_in.op   = cat_pkg::OP_READ;
                ctl_in.rd_a = 1'b1;
                ctl_in.rd_b = 1'b1;
            end
            cat_pkg::REQ_READ_ONE:
            begin
                ctl_in.op   = cat_pkg::OP_READ;
                ctl_in.rd_a = 1'b1;
            end
            cat_pkg::REQ_KILL:
            begin
                ctl_in.op = cat_pkg::OP_KILL;
            end
            // a read straight after a clear never finds a copy
            cat_pkg::REQ_CLEAR, cat_pkg::REQ_CLEAR_READ:
            begin
                ctl_in.op = cat_pkg::OP_CLEAR;
            end
            default:
            begin
                ctl_in.op = cat_pkg::OP_NOP;
            end
        endcase
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_valid && q_ready;

    assign q_ctl  = q_ctl_reg[rptr_reg];
    assign q_dest = q_dest_reg[rptr_reg];
    assign q_a    = q_a_reg[rptr_reg];
    assign q_b    = q_b_reg[rptr_reg];

    // Store queue entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_ctl_reg[wptr_reg]  <= ctl_in;
            q_dest_reg[wptr_reg] <= in_dest;
            q_a_reg[wptr_reg]    <= in_a;
            q_b_reg[wptr_reg]    <= in_b;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

@@ rtl/cat_back.sv @@
// Back end of the copy alias table: holds the pair table, scans it one
// entry a cycle for lookups and kills, inserts copies and registers the
// result. Depends on cat_pkg.
`timescale 1ns / 1ps

module cat_back #(
    parameter int TABLE_ENTRIES = cat_pkg::TABLE_ENTRIES,
    parameter int VAR_ID_BITS   = cat_pkg::VAR_ID_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // queue head from the front end
    input  logic                   q_valid,
    output logic                   q_ready,
    input  cat_pkg::ctl_t          q_ctl,
    input  logic [VAR_ID_BITS-1:0] q_dest,
    input  logic [VAR_ID_BITS-1:0] q_a,
    input  logic [VAR_ID_BITS-1:0] q_b,
    // result side
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [VAR_ID_BITS-1:0] out_a,
    output logic [VAR_ID_BITS-1:0] out_b,
    output logic                   out_changed,
    output logic                   out_full
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;
    typedef enum logic [1:0] {P_MAIN, P_FIND, P_COPY} phase_t;

    // pair table
    logic [VAR_ID_BITS-1:0]   key_mem [TABLE_ENTRIES];
    logic [VAR_ID_BITS-1:0]   val_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [VAR_ID_BITS-1:0]   rd_key_reg;
    logic [VAR_ID_BITS-1:0]   rd_val_reg;

    state_t                   state_reg;
    phase_t                   phase_reg;
    cat_pkg::ctl_t            ctl_reg;
    logic [VAR_ID_BITS-1:0]   dest_reg;
    logic [VAR_ID_BITS-1:0]   a_reg;
    logic [VAR_ID_BITS-1:0]   b_reg;
    logic                     chg_reg;
    logic                     ra_hit_reg;
    logic [VAR_ID_BITS-1:0]   ra_val_reg;
    logic                     rb_hit_reg;
    logic [VAR_ID_BITS-1:0]   rb_val_reg;
    logic                     free_found_reg;
    logic [IW-1:0]            free_idx_reg;
    logic                     issue_reg;
    logic [IW-1:0]            addr_reg;
    logic                     pend_reg;
    logic [IW-1:0]            pidx_reg;
    logic                     out_valid_reg;
    logic [VAR_ID_BITS-1:0]   out_a_reg;
    logic [VAR_ID_BITS-1:0]   out_b_reg;
    logic                     out_chg_reg;
    logic                     out_full_reg;

    logic                     p_vld;
    logic                     key_a_hit;
    logic                     key_b_hit;
    logic                     kill_hit;
    logic                     scan_done;
    logic                     op_kills;
    logic                     a_repl;
    logic                     b_repl;
    logic                     out_take;
    logic                     ins_en;
    logic [VAR_ID_BITS-1:0]   ins_val;

    // Compare the entry that has just been read
    assign p_vld     = valid_reg[pidx_reg];
    assign key_a_hit = p_vld && (rd_key_reg == a_reg);
    assign key_b_hit = p_vld && (rd_key_reg == b_reg);
    assign kill_hit  = p_vld && ((rd_key_reg == dest_reg) || (rd_val_reg == dest_reg));
    assign scan_done = !issue_reg && !pend_reg;
    assign op_kills  = (ctl_reg.op == cat_pkg::OP_KILL) || (ctl_reg.op == cat_pkg::OP_COMPUTE);

    // Final operand replacement and insertion
    assign a_repl   = ctl_reg.rd_a && ra_hit_reg && (ra_val_reg != a_reg);
    assign b_repl   = ctl_reg.rd_b && rb_hit_reg && (rb_val_reg != b_reg);
    assign out_take = !out_valid_reg || out_ready;
    assign ins_en   = (state_reg == S_FIN) && out_take &&
                      (ctl_reg.op == cat_pkg::OP_COPY) && free_found_reg;
    assign ins_val  = ra_hit_reg ? ra_val_reg : a_reg;

    assign q_ready     = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign out_a       = out_a_reg;
    assign out_b       = out_b_reg;
    assign out_changed = out_chg_reg;
    assign out_full    = out_full_reg;

    // Table storage: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ins_en)
        begin
            key_mem[free_idx_reg] <= dest_reg;
            val_mem[free_idx_reg] <= ins_val;
        end
        rd_key_reg <= key_mem[addr_reg];
        rd_val_reg <= val_mem[addr_reg];
    end

    // Sequencer, valid bits and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= P_MAIN;
            ctl_reg        <= '0;
            dest_reg       <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            chg_reg        <= 1'b0;
            ra_hit_reg     <= 1'b0;
            ra_val_reg     <= '0;
            rb_hit_reg     <= 1'b0;
            rb_val_reg     <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            issue_reg      <= 1'b0;
            addr_reg       <= '0;
            pend_reg       <= 1'b0;
            pidx_reg       <= '0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_a_reg      <= '0;
            out_b_reg      <= '0;
            out_chg_reg    <= 1'b0;
            out_full_reg   <= 1'b0;
        end
        else
        begin
            // read pipeline: data for the issued address arrives in the following cycle
            pend_reg <= issue_reg;
            pidx_reg <= addr_reg;

            // drop the result once taken, unless a new one replaces it
            if (out_valid_reg && out_ready && (state_reg != S_FIN))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        ctl_reg        <= q_ctl;
                        dest_reg       <= q_dest;
                        a_reg          <= q_a;
                        b_reg          <= q_b;
                        chg_reg        <= 1'b0;
                        ra_hit_reg     <= 1'b0;
                        rb_hit_reg     <= 1'b0;
                        free_found_reg <= 1'b0;
                        addr_reg       <= '0;
                        unique case (q_ctl.op)
                            cat_pkg::OP_NOP:
                            begin
                                state_reg <= S_FIN;
                            end
                            cat_pkg::OP_CLEAR:
                            begin
                                valid_reg <= '0;
                                state_reg <= S_FIN;
                            end
                            cat_pkg::OP_COPY:
                            begin
                                phase_reg <= P_FIND;
                                issue_reg <= 1'b1;
                                state_reg <= S_SCAN;
                            end
                            default:
                            begin
                                phase_reg <= P_MAIN;
                                issue_reg <= 1'b1;
                                state_reg <= S_SCAN;
                            end
                        endcase
                    end
                end

                S_SCAN:
                begin
                    // advance the scan address
                    if (issue_reg)
                    begin
                        if (addr_reg == LAST_IDX)
                        begin
                            issue_reg <= 1'b0;
                        end
                        else
                        begin
                            addr_reg <= addr_reg + 1'b1;
                        end
                    end

                    // handle the entry that has arrived
                    if (pend_reg)
                    begin
                        unique case (phase_reg)
                            P_FIND:
                            begin
                                if (key_a_hit)
                                begin
                                    ra_hit_reg <= 1'b1;
                                    ra_val_reg <= rd_val_reg;
                                end
                            end
                            P_COPY:
                            begin
                                if (kill_hit)
                                begin
                                    valid_reg[pidx_reg] <= 1'b0;
                                end
                                else if (key_a_hit)
                                begin
                                    ra_hit_reg <= 1'b1;
                                    ra_val_reg <= rd_val_reg;
                                end
                                if ((!p_vld || kill_hit) && !free_found_reg)
                                begin
                                    free_found_reg <= 1'b1;
                                    free_idx_reg   <= pidx_reg;
                                end
                            end
                            default:
                            begin
                                if (key_a_hit)
                                begin
                                    ra_hit_reg <= 1'b1;
                                    ra_val_reg <= rd_val_reg;
                                end
                                if (key_b_hit)
                                begin
                                    rb_hit_reg <= 1'b1;
                                    rb_val_reg <= rd_val_reg;
                                end
                                if (op_kills && kill_hit)
                                begin
                                    valid_reg[pidx_reg] <= 1'b0;
                                end
                            end
                        endcase
                    end

                    // end of pass: rewrite the copy source, or finish
                    if (scan_done)
                    begin
                        if (phase_reg == P_FIND)
                        begin
                            if (ra_hit_reg && (ra_val_reg != a_reg))
                            begin
                                a_reg   <= ra_val_reg;
                                chg_reg <= 1'b1;
                            end
                            ra_hit_reg <= 1'b0;
                            phase_reg  <= P_COPY;
                            addr_reg   <= '0;
                            issue_reg  <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_FIN;
                        end
                    end
                end

                S_FIN:
                begin
                    if (out_take)
                    begin
                        out_valid_reg <= 1'b1;
                        out_a_reg     <= a_repl ? ra_val_reg : a_reg;
                        out_b_reg     <= b_repl ? rb_val_reg : b_reg;
                        out_chg_reg   <= chg_reg || a_repl || b_repl;
                        out_full_reg  <= (ctl_reg.op == cat_pkg::OP_COPY) && !free_found_reg;
                        if (ins_en)
                        begin
                            valid_reg[free_idx_reg] <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                    else if (out_valid_reg && out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/copy_alias_table.sv @@
// Top level of the copy alias table: stream ports, id width adaption,
// front end and back end. Depends on cat_pkg, cat_front and cat_back.
`timescale 1ns / 1ps

// Local copy propagation over a table of copy pairs (destination -> source).
// Input channel s_axis_*: one three-address request per item; tuser carries
// the request kind and the label flag, tdata the three variable ids.
// Output channel m_axis_*: exactly one result item per request, in order;
// tdata carries both operands after propagation, tuser the changed and
// table-full flags.
// Requests pass through a two-entry queue into a back end that walks the
// table one entry a cycle through its single registered read port, so
// with N = TABLE_ENTRIES:
//   read, compute and kill take one pass over the N entries,
//   copy takes two passes,
//   clear, clear-then-read, label copies and unused kinds take no pass.
// The queue keeps accepting while the back end works, up to two items.
// Reset empties the table and the queue at once; no clearing pass.
// A stalled receiver holds the result in the output register; the back end
// may still finish its scan and then waits until the result is taken.

module copy_alias_table #(
    parameter int TABLE_ENTRIES = cat_pkg::TABLE_ENTRIES,
    parameter int VAR_ID_BITS   = cat_pkg::VAR_ID_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // dest_var[15:0], src_a[31:16], src_b[47:32]
    input  logic [3:0]  s_axis_tuser,   // req_type[2:0], src_is_label[3]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_src_a[15:0], out_src_b[31:16]
    output logic [1:0]  m_axis_tuser    // changed[0], table_full[1]
);

    logic [31:0]            dest32;
    logic [31:0]            a32;
    logic [31:0]            b32;
    logic [VAR_ID_BITS-1:0] in_dest;
    logic [VAR_ID_BITS-1:0] in_a;
    logic [VAR_ID_BITS-1:0] in_b;

    logic                   q_valid;
    logic                   q_ready;
    cat_pkg::ctl_t          q_ctl;
    logic [VAR_ID_BITS-1:0] q_dest;
    logic [VAR_ID_BITS-1:0] q_a;
    logic [VAR_ID_BITS-1:0] q_b;

    logic [VAR_ID_BITS-1:0] res_a;
    logic [VAR_ID_BITS-1:0] res_b;
    logic [31:0]            res_a32;
    logic [31:0]            res_b32;
    logic                   res_chg;
    logic                   res_full;

    // Take ids modulo the internal id width
    assign dest32  = 32'(s_axis_tdata[15:0]);
    assign a32     = 32'(s_axis_tdata[31:16]);
    assign b32     = 32'(s_axis_tdata[47:32]);
    assign in_dest = dest32[VAR_ID_BITS-1:0];
    assign in_a    = a32[VAR_ID_BITS-1:0];
    assign in_b    = b32[VAR_ID_BITS-1:0];

    cat_front #(
        .VAR_ID_BITS (VAR_ID_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_req   (s_axis_tuser[2:0]),
        .in_label (s_axis_tuser[3]),
        .in_dest  (in_dest),
        .in_a     (in_a),
        .in_b     (in_b),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_ctl    (q_ctl),
        .q_dest   (q_dest),
        .q_a      (q_a),
        .q_b      (q_b)
    );

    cat_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .VAR_ID_BITS   (VAR_ID_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_ctl       (q_ctl),
        .q_dest      (q_dest),
        .q_a         (q_a),
        .q_b         (q_b),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_a       (res_a),
        .out_b       (res_b),
        .out_changed (res_chg),
        .out_full    (res_full)
    );

    // Pack the result onto the 16-bit port fields
    assign res_a32      = 32'(res_a);
    assign res_b32      = 32'(res_b);
    assign m_axis_tdata = {res_b32[15:0], res_a32[15:0]};
    assign m_axis_tuser = {res_full, res_chg};

endmodule

@@ test/alias_table_checker.sv @@
// Checker for copy_alias_table: watches both stream channels, predicts each result and compares.
// Depends on cat_pkg for the request kinds, the table size and the id width.
`timescale 1ns / 1ps

module alias_table_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,    // dest_var[15:0], src_a[31:16], src_b[47:32]
    input  logic [3:0]  s_tuser,    // req_type[2:0], src_is_label[3]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,    // out_src_a[15:0], out_src_b[31:16]
    input  logic [1:0]  m_tuser,    // changed[0], table_full[1]
    output int          errors,
    output int          outstanding
);

    typedef logic [cat_pkg::VAR_ID_BITS-1:0] var_id_t;

    typedef struct packed {
        logic    full;
        logic    changed;
        var_id_t src_b;
        var_id_t src_a;
    } outcome_t;

    // Own copy of the alias table
    logic    alias_live [cat_pkg::TABLE_ENTRIES];
    var_id_t alias_dest [cat_pkg::TABLE_ENTRIES];
    var_id_t alias_orig [cat_pkg::TABLE_ENTRIES];

    outcome_t predicted_q [$];
    int       fail_count = 0;

    function automatic int lookup_alias(var_id_t id);
        for (int i = 0; i < cat_pkg::TABLE_ENTRIES; i++)
            if (alias_live[i] && alias_dest[i] == id)
                return i;
        return -1;
    endfunction

    task automatic clear_aliases();
        for (int i = 0; i < cat_pkg::TABLE_ENTRIES; i++)
            alias_live[i] = 1'b0;
    endtask

    // Replace an operand by its recorded copy, unless that copy is itself
    task automatic propagate_operand(inout var_id_t id, inout logic changed);
        int hit;
        hit = lookup_alias(id);
        if (hit >= 0)
        begin
            if (alias_orig[hit] != id)
            begin
                changed = 1'b1;
                id      = alias_orig[hit];
            end
        end
    endtask

    // Drop every pair that names the variable on either side
    task automatic kill_aliases(var_id_t d);
        for (int i = 0; i < cat_pkg::TABLE_ENTRIES; i++)
            if (alias_live[i] && (alias_dest[i] == d || alias_orig[i] == d))
                alias_live[i] = 1'b0;
    endtask

    // Kill the destination, then store it in the lowest free slot
    task automatic record_alias(var_id_t d, var_id_t s, output logic full);
        int      hit;
        int      slot;
        var_id_t target;
        kill_aliases(d);
        hit    = lookup_alias(s);
        target = (hit >= 0) ? alias_orig[hit] : s;
        slot   = -1;
        for (int i = 0; i < cat_pkg::TABLE_ENTRIES; i++)
            if (slot < 0 && !alias_live[i])
                slot = i;
        full = (slot < 0);
        if (slot >= 0)
        begin
            alias_live[slot] = 1'b1;
            alias_dest[slot] = d;
            alias_orig[slot] = target;
        end
    endtask

    task automatic predict_request(logic [2:0] kind, var_id_t d, var_id_t a, var_id_t b,
                                   logic label, output outcome_t res);
        res.src_a   = a;
        res.src_b   = b;
        res.changed = 1'b0;
        res.full    = 1'b0;
        unique case (kind)
            cat_pkg::REQ_COPY:
            begin
                if (!label)
                begin
                    propagate_operand(res.src_a, res.changed);
                    record_alias(d, res.src_a, res.full);
                end
            end
            cat_pkg::REQ_COMPUTE:
            begin
                propagate_operand(res.src_a, res.changed);
                propagate_operand(res.src_b, res.changed);
                kill_aliases(d);
            end
            cat_pkg::REQ_READ_PAIR:
            begin
                propagate_operand(res.src_a, res.changed);
                propagate_operand(res.src_b, res.changed);
            end
            cat_pkg::REQ_READ_ONE:
                propagate_operand(res.src_a, res.changed);
            cat_pkg::REQ_KILL:
                kill_aliases(d);
            cat_pkg::REQ_CLEAR:
                clear_aliases();
            cat_pkg::REQ_CLEAR_READ:
            begin
                clear_aliases();
                propagate_operand(res.src_a, res.changed);
            end
            default:
                ;
        endcase
    endtask

    // Compare the item leaving first, then predict the item entering
    always @(posedge clk)
    begin : watch
        outcome_t want;
        outcome_t pred;
        if (!rst_n)
        begin
            clear_aliases();
            predicted_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (predicted_q.size() == 0)
                begin
                    $error("result item with no expectation: tdata %h tuser %h",
                           m_tdata, m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = predicted_q.pop_front();
                    if (m_tdata[15:0] !== want.src_a)
                    begin
                        $error("out_src_a: expected %h, got %h", want.src_a, m_tdata[15:0]);
                        fail_count++;
                    end
                    if (m_tdata[31:16] !== want.src_b)
                    begin
                        $error("out_src_b: expected %h, got %h", want.src_b, m_tdata[31:16]);
                        fail_count++;
                    end
                    if (m_tuser[0] !== want.changed)
                    begin
                        $error("changed: expected %b, got %b", want.changed, m_tuser[0]);
                        fail_count++;
                    end
                    if (m_tuser[1] !== want.full)
                    begin
                        $error("table_full: expected %b, got %b", want.full, m_tuser[1]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                predict_request(s_tuser[2:0], s_tdata[15:0], s_tdata[31:16], s_tdata[47:32],
                                s_tuser[3], pred);
                predicted_q.push_back(pred);
            end
        end
        outstanding <= predicted_q.size();
        errors      <= fail_count;
    end

endmodule

@@ test/tb_copy_alias_table.sv @@
// Testbench top for copy_alias_table: clock, reset, request stimulus and result back-pressure.
// Depends on cat_pkg, copy_alias_table and alias_table_checker.
`timescale 1ns / 1ps

module tb_copy_alias_table;

    typedef logic [cat_pkg::VAR_ID_BITS-1:0] var_id_t;

    localparam logic [2:0] REQ_UNUSED   = 3'd7;
    localparam int         RANDOM_ITEMS = 500;
    localparam int         CYCLE_LIMIT  = 500000;
    localparam int         SETTLE       = 2 * cat_pkg::TABLE_ENTRIES + 16;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;     // dest_var[15:0], src_a[31:16], src_b[47:32]
    logic [3:0]  s_axis_tuser;     // req_type[2:0], src_is_label[3]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;     // out_src_a[15:0], out_src_b[31:16]
    logic [1:0]  m_axis_tuser;     // changed[0], table_full[1]

    int errors;
    int outstanding;
    int cycles = 0;
    int calm_tx = 0;
    int calm_rx = 0;

    copy_alias_table u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    alias_table_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .s_tdata     (s_axis_tdata),
        .s_tuser     (s_axis_tuser),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata),
        .m_tuser     (m_axis_tuser),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_copy_alias_table failed");
            $finish;
        end
    end

    // Gap length: mostly none or short, now and then long, with calm stretches
    task automatic idle_length(inout int calm, output int len);
        int pick;
        pick = $urandom_range(0, 99);
        if (calm > 0)
        begin
            calm--;
            len = 0;
        end
        else if (pick < 2)
        begin
            calm = $urandom_range(20, 40);
            len  = 0;
        end
        else if (pick < 55)
            len = 0;
        else if (pick < 85)
            len = $urandom_range(1, 3);
        else if (pick < 97)
            len = $urandom_range(4, 10);
        else
            len = $urandom_range(20, 60);
    endtask

    // Ids mostly from a small pool so that pairs hit, with extremes and full-range noise
    function automatic var_id_t rand_id();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return var_id_t'($urandom_range(1, 12));
        else if (pick < 76)
            return '0;
        else if (pick < 82)
            return '1;
        else if (pick < 86)
            return (pick[0]) ? var_id_t'(16'h8000) : var_id_t'(16'h7fff);
        else
            return var_id_t'($urandom());
    endfunction

    // Present one item from a falling edge and hold it until accepted
    task automatic send_request(logic [2:0] kind, var_id_t d, var_id_t a, var_id_t b,
                                logic label);
        int gap;
        idle_length(calm_tx, gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= {b, a, d};
        s_axis_tuser  <= {label, kind};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Result side back-pressure
    initial
    begin
        int pause;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge clk);
            idle_length(calm_rx, pause);
            if (pause > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (pause) @(negedge clk);
            end
        end
    end

    initial
    begin
        int         sent;
        int         burst;
        int         pick;
        logic [2:0] kind;
        bit         drained;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty table, chains, label copy, self copy, kills, clears, extremes
        send_request(cat_pkg::REQ_READ_ONE,   16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_request(cat_pkg::REQ_COPY,       16'h0001, 16'h0002, 16'hffff, 1'b0);
        send_request(cat_pkg::REQ_READ_PAIR,  16'h0000, 16'h0001, 16'h0001, 1'b0);
        send_request(cat_pkg::REQ_COPY,       16'h0003, 16'h0001, 16'h0000, 1'b0);
        send_request(cat_pkg::REQ_COPY,       16'h0005, 16'h0001, 16'h0000, 1'b1);
        send_request(cat_pkg::REQ_READ_ONE,   16'h0000, 16'h0005, 16'h0000, 1'b0);
        send_request(cat_pkg::REQ_COPY,       16'h0002, 16'hffff, 16'h0000, 1'b0);
        send_request(cat_pkg::REQ_READ_PAIR,  16'h0000, 16'h0001, 16'h0003, 1'b0);
        send_request(cat_pkg::REQ_READ_ONE,   16'h0000, 16'h0002, 16'h0000, 1'b0);
        send_request(cat_pkg::REQ_COPY,       16'h0007, 16'h0007, 16'h0000, 1'b0);
        send_request(cat_pkg::REQ_READ_ONE,   16'h0000, 16'h0007, 16'h0000, 1'b0);
        send_request(cat_pkg::REQ_COMPUTE,    16'h0002, 16'h0002, 16'h0002, 1'b0);
        send_request(cat_pkg::REQ_READ_ONE,   16'h0000, 16'h0002, 16'h0000, 1'b0);
        send_request(cat_pkg::REQ_COPY,       16'hffff, 16'h0000, 16'h0000, 1'b0);
        send_request(cat_pkg::REQ_COPY,       16'h0000, 16'hffff, 16'h0000, 1'b0);
        send_request(cat_pkg::REQ_READ_PAIR,  16'h0000, 16'h0000, 16'hffff, 1'b0);
        send_request(cat_pkg::REQ_KILL,       16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_request(cat_pkg::REQ_READ_ONE,   16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_request(cat_pkg::REQ_COPY,       16'h000a, 16'h000b, 16'h0000, 1'b0);
        send_request(cat_pkg::REQ_CLEAR_READ, 16'h0000, 16'h000a, 16'h000a, 1'b0);
        send_request(cat_pkg::REQ_COPY,       16'h8000, 16'h7fff, 16'h0000, 1'b0);
        send_request(cat_pkg::REQ_CLEAR,      16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_request(cat_pkg::REQ_READ_PAIR,  16'h0000, 16'h8000, 16'h8000, 1'b0);
        send_request(REQ_UNUSED,              16'hffff, 16'hffff, 16'hffff, 1'b1);

        // Hold the sender until the directed results are all back
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        @(negedge clk);

        // Random: single requests plus refill bursts that run the table near or past full
        sent    = 0;
        drained = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent == 0 || $urandom_range(0, 59) == 0)
            begin
                burst = $urandom_range(cat_pkg::TABLE_ENTRIES - 2, cat_pkg::TABLE_ENTRIES + 8);
                send_request(cat_pkg::REQ_CLEAR, rand_id(), rand_id(), rand_id(), 1'b0);
                for (int i = 0; i < burst; i++)
                    send_request(cat_pkg::REQ_COPY, var_id_t'(16'h1000 + i), rand_id(),
                                 rand_id(), 1'b0);
                sent += burst + 1;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 34)
                    kind = cat_pkg::REQ_COPY;
                else if (pick < 48)
                    kind = cat_pkg::REQ_COMPUTE;
                else if (pick < 63)
                    kind = cat_pkg::REQ_READ_PAIR;
                else if (pick < 80)
                    kind = cat_pkg::REQ_READ_ONE;
                else if (pick < 92)
                    kind = cat_pkg::REQ_KILL;
                else if (pick < 95)
                    kind = cat_pkg::REQ_CLEAR;
                else if (pick < 98)
                    kind = cat_pkg::REQ_CLEAR_READ;
                else
                    kind = REQ_UNUSED;
                send_request(kind, rand_id(), rand_id(), rand_id(),
                             ($urandom_range(0, 9) == 0));
                sent++;
            end

            // Drain once midway with the sender idle
            if (!drained && sent >= RANDOM_ITEMS / 2)
            begin
                drained = 1'b1;
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (outstanding != 0)
                    @(posedge clk);
                @(negedge clk);
            end
        end

        // Wait for the last results, then let the block settle
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (outstanding != 0)
            $error("%0d expected results never arrived", outstanding);
        if (errors == 0 && outstanding == 0)
            $display("tb_copy_alias_table passed");
        else
            $display("tb_copy_alias_table failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/cat_pkg.sv
rtl/cat_front.sv
rtl/cat_back.sv
rtl/copy_alias_table.sv
test/alias_table_checker.sv
test/tb_copy_alias_table.sv
